// File: rtl/core/rbct_pkg.sv
// Package for the ring buffer claim tracker: shared widths, command,
// status and register codes, controller states and the memory control struct.
// No dependencies.
package rbct_pkg;

  // Parameter defaults
  localparam int MaxReadersDef = 8;
  localparam int MarkBitsDef   = 32;

  // Fixed field widths
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;
  localparam int SizeW    = 17;
  localparam int CountW   = 17;
  localparam int IdW      = 4;
  localparam int StatusW  = 3;
  localparam int OffsetW  = 16;
  localparam int AvailW   = 17;

  // Register reset values and limits
  localparam logic [SizeW-1:0]  SizeMax      = 17'd65536;
  localparam logic [SizeW-1:0]  BufSizeRst   = 17'd65536;
  localparam logic [CountW-1:0] MaxWrRst     = 17'd4096;
  localparam logic [CountW-1:0] MaxRdRst     = 17'd4096;
  localparam logic [IdW-1:0]    NumRdrRst    = 4'd0;

  typedef enum logic [1:0] {
    CMD_CLAIM_WR   = 2'd0,
    CMD_RELEASE_WR = 2'd1,
    CMD_CLAIM_RD   = 2'd2,
    CMD_RELEASE_RD = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_TOO_MANY = 3'd1,
    ST_BUSY     = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_NO_DATA  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUF_SIZE = 2'd0,
    CFG_MAX_WR   = 2'd1,
    CFG_MAX_RD   = 2'd2,
    CFG_NUM_RDR  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FIN
  } state_e;

  // Reader memory access control
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

// File: rtl/core/rbct_ifs.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on rbct_pkg for field widths.
interface rbct_cmd_if;
  import rbct_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [CountW-1:0] count;
  logic [IdW-1:0]    reader_id;

  modport source (output valid, cmd, count, reader_id, input ready);
  modport sink   (input valid, cmd, count, reader_id, output ready);
endinterface

interface rbct_rsp_if;
  import rbct_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [OffsetW-1:0] offset;
  logic [AvailW-1:0]  avail;

  modport source (output valid, status, offset, avail, input ready);
  modport sink   (input valid, status, offset, avail, output ready);
endinterface

// File: rtl/core/rbct_urem.sv
// Bit-serial unsigned remainder: mark modulo buffer size, one dividend bit
// per cycle. Depends on rbct_pkg.
module rbct_urem #(
  parameter int DivdW = rbct_pkg::MarkBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DivdW-1:0]           dividend_i,
  input  logic [rbct_pkg::SizeW-1:0] divisor_i,
  output logic                       done_o,
  output logic [rbct_pkg::OffsetW-1:0] rem_o
);
  import rbct_pkg::*;

  localparam int CntW = $clog2(DivdW + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivdW-1:0] dvd_q;
  logic [SizeW-1:0] dvs_q;
  logic [SizeW-1:0] rem_q;
  logic [SizeW:0]   trial;
  logic [SizeW:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial  = {rem_q, dvd_q[DivdW-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q[OffsetW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivdW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      dvd_q <= {dvd_q[DivdW-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, dvs_q}) ? diff[SizeW-1:0] : trial[SizeW-1:0];
    end
  end

endmodule

// File: rtl/core/rbct_rdr_mem.sv
// Per-reader region memory: {start mark, end mark} per reader, one port,
// registered read. Entries never written read as zero. Depends on rbct_pkg.
module rbct_rdr_mem #(
  parameter int Depth = rbct_pkg::MaxReadersDef,
  parameter int AddrW = 3,
  parameter int DataW = 2 * rbct_pkg::MarkBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbct_pkg::mem_ctl_t  ctl_i,
  input  logic [AddrW-1:0]    addr_i,
  input  logic [DataW-1:0]    wdata_i,
  output logic [DataW-1:0]    rdata_o
);
  import rbct_pkg::*;

  logic [DataW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic             rvld_q;
  logic [DataW-1:0] rdata_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  // Written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rvld_q <= vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/core/ring_buffer_claim_tracker.sv
// Ring buffer claim tracker: one writer, up to MAX_READERS readers.
// Commands arrive on cmd_ch (valid/ready); each command yields exactly one
// response on rsp_ch carrying status, the buffer offset of a claimed region
// and the elements available to read after the command.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must do so only while no command is in flight (the block does not check).
// Path from command transfer to response valid:
//   failed commands and write releases: prepare, decide, response register
//   successful claims: in addition the bit-serial remainder
//   unit that folds the start mark into a buffer offset
//   successful read releases: in addition the scan over
//   the reader memory (one read and one compare per reader)
// One command is processed at a time; a new command is taken as soon as the
// previous one has been moved into the response register, even while that
// response still waits for the receiver. A stalled receiver holds the
// response and, once a second result is ready, holds the controller.
// Reset clears all marks, busy flags and written flags of the reader memory
// and loads the register defaults; no clearing pass is needed.
module ring_buffer_claim_tracker #(
  parameter int MAX_READERS = rbct_pkg::MaxReadersDef,
  parameter int MARK_BITS   = rbct_pkg::MarkBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbct_cmd_if.sink                      cmd_ch,
  rbct_rsp_if.source                    rsp_ch,
  input  logic                          cfg_we_i,
  input  logic [rbct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbct_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rbct_pkg::*;

  localparam int MW = MARK_BITS;
  localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  state_e state_q, state_d;

  // Configuration registers
  logic [SizeW-1:0]  buf_size_q;
  logic [CountW-1:0] max_wr_q;
  logic [CountW-1:0] max_rd_q;
  logic [IdW-1:0]    num_rdr_q;

  // Tracker state
  logic [MW-1:0]          wr_start_q, wr_end_q, rd_mark_q, free_mark_q;
  logic                   wr_busy_q;
  logic [MAX_READERS-1:0] rbusy_q;

  // Command in flight
  cmd_e              cmd_q;
  logic [CountW-1:0] count_q;
  logic [IdW-1:0]    id_q;
  logic [RW-1:0]     rid_q;
  logic [MW-1:0]     used_q, dav_q, min_q;
  logic              idok_q;
  status_e           status_q;
  logic [OffsetW-1:0] offset_q;
  logic [IdW-1:0]    scan_q;

  // Response register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [OffsetW-1:0] out_offset_q;
  logic [AvailW-1:0]  out_avail_q;

  // Control
  logic       cmd_xfer, out_load, div_start, div_done, ok;
  mem_ctl_t   mem_ctl;
  logic [RW-1:0] mem_addr;
  status_e    st_dec;

  logic [SizeW-1:0]   bs_eff;
  logic [IdW-1:0]     n_eff;
  logic [MW-1:0]      lim, avail_now, cnt_ext, mem_v;
  logic [AvailW-1:0]  avail_sat;
  logic [SizeW-1:0]   space;
  logic [2*MW-1:0]    mem_wdata, mem_rdata;
  logic [MW-1:0]      rd_start, rd_end;
  logic [OffsetW-1:0] div_rem;
  logic               scan_end;

  // Effective size and reader count
  always_comb begin
    if (buf_size_q == '0) begin
      bs_eff = SizeW'(1);
    end else if (buf_size_q > SizeMax) begin
      bs_eff = SizeMax;
    end else begin
      bs_eff = buf_size_q;
    end
  end

  assign n_eff = (num_rdr_q > IdW'(MAX_READERS)) ? IdW'(MAX_READERS) : num_rdr_q;

  // Data available and its saturated form
  assign lim       = wr_busy_q ? wr_start_q : wr_end_q;
  assign avail_now = lim - rd_mark_q;
  assign avail_sat = (|avail_now[MW-1:AvailW]) ? '1 : avail_now[AvailW-1:0];
  assign cnt_ext   = MW'(count_q);
  // Room in front of the free mark; zero once a shrunk buffer is overfull
  assign space     = (used_q > MW'(bs_eff)) ? '0 : bs_eff - used_q[SizeW-1:0];

  assign rd_start  = mem_rdata[2*MW-1:MW];
  assign rd_end    = mem_rdata[MW-1:0];
  assign mem_v     = rbusy_q[scan_q[RW-1:0]] ? rd_start : rd_end;
  assign mem_wdata = {rd_mark_q, rd_mark_q + cnt_ext};
  assign scan_end  = (scan_q == n_eff);

  // Status of the command in flight, in check order
  always_comb begin
    st_dec = ST_OK;
    unique case (cmd_q)
      CMD_CLAIM_WR: begin
        if (count_q > max_wr_q) begin
          st_dec = ST_TOO_MANY;
        end else if (wr_busy_q) begin
          st_dec = ST_BUSY;
        end else if (count_q > space) begin
          st_dec = ST_NO_SPACE;
        end
      end
      CMD_RELEASE_WR: begin
        if (!wr_busy_q) begin
          st_dec = ST_BUSY;
        end
      end
      CMD_CLAIM_RD: begin
        if (count_q > max_rd_q) begin
          st_dec = ST_TOO_MANY;
        end else if (!idok_q) begin
          st_dec = ST_BAD_ID;
        end else if (rbusy_q[rid_q]) begin
          st_dec = ST_BUSY;
        end else if (cnt_ext > dav_q) begin
          st_dec = ST_NO_DATA;
        end
      end
      CMD_RELEASE_RD: begin
        if (!idok_q) begin
          st_dec = ST_BAD_ID;
        end else if (!rbusy_q[rid_q]) begin
          st_dec = ST_BUSY;
        end
      end
      default: st_dec = ST_OK;
    endcase
  end

  assign ok = (st_dec == ST_OK);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (cmd_ch.valid) state_d = S_PREP;
      S_PREP:     state_d = S_DECIDE;
      S_DECIDE: begin
        if (ok && ((cmd_q == CMD_CLAIM_WR) || (cmd_q == CMD_CLAIM_RD))) begin
          state_d = S_DIV;
        end else if (ok && (cmd_q == CMD_RELEASE_RD)) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV:      if (div_done) state_d = S_FIN;
      S_SCAN_RD:  state_d = scan_end ? S_FIN : S_SCAN_CMP;
      S_SCAN_CMP: state_d = S_SCAN_RD;
      S_FIN:      if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_ch.ready = 1'b0;
    mem_ctl      = '0;
    mem_addr     = rid_q;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: cmd_ch.ready = 1'b1;
      S_PREP: mem_ctl.rd = 1'b1;
      S_DECIDE: begin
        mem_ctl.wr = ok && (cmd_q == CMD_CLAIM_RD);
        div_start  = ok && ((cmd_q == CMD_CLAIM_WR) || (cmd_q == CMD_CLAIM_RD));
      end
      S_SCAN_RD: begin
        mem_ctl.rd = !scan_end;
        mem_addr   = scan_q[RW-1:0];
      end
      S_FIN: out_load = !out_valid_q || rsp_ch.ready;
      default: ;
    endcase
  end

  assign cmd_xfer = cmd_ch.valid && cmd_ch.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BufSizeRst;
      max_wr_q   <= MaxWrRst;
      max_rd_q   <= MaxRdRst;
      num_rdr_q  <= NumRdrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BUF_SIZE: buf_size_q <= cfg_wdata_i[SizeW-1:0];
        CFG_MAX_WR:   max_wr_q   <= cfg_wdata_i[CountW-1:0];
        CFG_MAX_RD:   max_rd_q   <= cfg_wdata_i[CountW-1:0];
        CFG_NUM_RDR:  num_rdr_q  <= cfg_wdata_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  // Controller and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_start_q  <= '0;
      wr_end_q    <= '0;
      wr_busy_q   <= 1'b0;
      rd_mark_q   <= '0;
      free_mark_q <= '0;
      rbusy_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DECIDE && ok) begin
        unique case (cmd_q)
          CMD_CLAIM_WR: begin
            wr_busy_q  <= 1'b1;
            wr_start_q <= wr_end_q;
            wr_end_q   <= wr_end_q + cnt_ext;
          end
          CMD_RELEASE_WR: wr_busy_q <= 1'b0;
          CMD_CLAIM_RD: begin
            rbusy_q[rid_q] <= 1'b1;
            rd_mark_q      <= rd_mark_q + cnt_ext;
          end
          CMD_RELEASE_RD: begin
            rbusy_q[rid_q] <= 1'b0;
            scan_q         <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == S_SCAN_RD && scan_end) begin
        free_mark_q <= min_q;
      end
      if (state_q == S_SCAN_CMP) begin
        scan_q <= scan_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command payload and working values
  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      cmd_q   <= cmd_e'(cmd_ch.cmd);
      count_q <= cmd_ch.count;
      id_q    <= cmd_ch.reader_id;
      rid_q   <= RW'(cmd_ch.reader_id - 1'b1);
    end
    if (state_q == S_PREP) begin
      used_q <= wr_end_q - free_mark_q;
      dav_q  <= avail_now;
      idok_q <= (id_q != '0) && (id_q <= n_eff);
    end
    if (state_q == S_DECIDE) begin
      status_q <= st_dec;
      offset_q <= '0;
      min_q    <= rd_end;
    end
    if (state_q == S_DIV && div_done) begin
      offset_q <= div_rem;
    end
    // Running minimum over the readers: start if busy, end if idle
    if (state_q == S_SCAN_CMP && (mem_v < min_q)) begin
      min_q <= mem_v;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_offset_q <= offset_q;
      out_avail_q  <= avail_sat;
    end
  end

  assign rsp_ch.valid  = out_valid_q;
  assign rsp_ch.status = out_status_q;
  assign rsp_ch.offset = out_offset_q;
  assign rsp_ch.avail  = out_avail_q;

  rbct_rdr_mem #(
    .Depth (MAX_READERS),
    .AddrW (RW),
    .DataW (2 * MW)
  ) u_rdr_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Claimed start mark folded into a buffer offset
  rbct_urem #(
    .DivdW (MW)
  ) u_urem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((cmd_q == CMD_CLAIM_WR) ? wr_end_q : rd_mark_q),
    .divisor_i  (bs_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

endmodule
